// ----- sv/ini_text_tokenizer_top_assert.svh -----
// Assertion macros for the tokenizer checker.
// Both expect signals named clk and arst_n in the enclosing scope.
`ifndef INI_TEXT_TOKENIZER_TOP_ASSERT_SVH
`define INI_TEXT_TOKENIZER_TOP_ASSERT_SVH

// Same-cycle implication.
`define ITT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ITT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/itt_pkg.sv -----
package itt_pkg;

	localparam int MAX_PEND = 15;
	localparam int CNT_W    = $clog2(MAX_PEND + 1);
	localparam int IDX_W    = (MAX_PEND > 1) ? $clog2(MAX_PEND) : 1;

	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	typedef enum logic [4:0] {
		PS_IDLE    = 5'b00001,
		PS_SECTION = 5'b00010,
		PS_KEY     = 5'b00100,
		PS_VALUE   = 5'b01000,
		PS_COMMENT = 5'b10000
	} pstate_t;

	typedef enum logic [1:0] {
		KIND_SECTION = 2'd0,
		KIND_KEY     = 2'd1,
		KIND_VALUE   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ACT_NONE = 2'd0,
		ACT_PUT  = 2'd1,
		ACT_END  = 2'd2
	} act_t;

	typedef struct packed {
		act_t    act;
		kind_t   kind;
		pstate_t nstate;
		logic    clear;
	} dec_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic pass;
		logic apply;
		logic emit;
		logic flush;
		logic flush_done;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		act_t act;
		logic blank;
		logic pend_any;
		logic flush_last;
		logic need_pass1;
		logic out_free;
	} stat_t;

	function automatic logic is_alnum(logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
			(c >= 8'h30 && c <= 8'h39);
	endfunction

	function automatic logic is_blank(logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

	function automatic dec_t decode(pstate_t ps, logic [7:0] c);
		dec_t d;
		d.act    = ACT_NONE;
		d.kind   = KIND_KEY;
		d.nstate = ps;
		d.clear  = 1'b0;
		unique case (ps)
			PS_IDLE: begin
				if (c == CH_LBRACK) begin
					d.clear  = 1'b1;
					d.nstate = PS_SECTION;
				end else if (c == CH_SEMI) begin
					d.nstate = PS_COMMENT;
				end else if (is_alnum(c)) begin
					d.clear  = 1'b1;
					d.nstate = PS_KEY;
					d.act    = ACT_PUT;
					d.kind   = KIND_KEY;
				end else begin
					d.act = ACT_NONE;
				end
			end
			PS_SECTION: begin
				d.kind = KIND_SECTION;
				if (is_alnum(c)) begin
					d.act = ACT_PUT;
				end else if (c == CH_RBRACK) begin
					d.act    = ACT_END;
					d.nstate = PS_IDLE;
				end else begin
					d.act = ACT_NONE;
				end
			end
			PS_KEY: begin
				d.kind = KIND_KEY;
				if (c != CH_EQ) begin
					d.act = ACT_PUT;
				end else begin
					d.act    = ACT_END;
					d.nstate = PS_VALUE;
				end
			end
			PS_VALUE: begin
				d.kind = KIND_VALUE;
				if (c == CH_NL || c == CH_CR || c == CH_SEMI) begin
					d.act    = ACT_END;
					d.nstate = (c == CH_SEMI) ? PS_COMMENT : PS_IDLE;
				end else begin
					d.act = ACT_PUT;
				end
			end
			PS_COMMENT: begin
				if (c == CH_NL) begin
					d.nstate = PS_IDLE;
				end
			end
			default: begin
				d.nstate = PS_IDLE;
			end
		endcase
		return d;
	endfunction

endpackage

// ----- sv/itt_if.sv -----
interface itt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface itt_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] token_kind;
	logic [7:0] token_byte;
	logic       token_end;
	logic       blanks_truncated;
	logic       last_of_run;

	modport source (output valid, output token_kind, output token_byte, output token_end,
		output blanks_truncated, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_byte, input token_end,
		input blanks_truncated, input last_of_run, output ready);
endinterface

// ----- sv/itt_ctrl.sv -----
module itt_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  itt_pkg::stat_t stat,
	output itt_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		C_IDLE  = 3'b001,
		C_EXEC  = 3'b010,
		C_FLUSH = 3'b100
	} cstate_t;

	cstate_t state_q, state_d;
	logic    pass_q, pass_d;
	logic    step_done;

	assign in_ready = (state_q == C_IDLE);

	always_comb begin
		cmd       = '0;
		cmd.pass  = pass_q;
		state_d   = state_q;
		pass_d    = pass_q;
		step_done = 1'b0;
		unique case (state_q)
			C_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					pass_d   = 1'b0;
					state_d  = C_EXEC;
				end
			end
			C_EXEC: begin
				priority if (stat.act == itt_pkg::ACT_NONE ||
					(stat.act == itt_pkg::ACT_PUT && stat.blank)) begin
					cmd.apply = 1'b1;
					step_done = 1'b1;
				end else if (stat.act == itt_pkg::ACT_PUT && stat.pend_any) begin
					state_d = C_FLUSH;
				end else if (stat.out_free) begin
					cmd.apply = 1'b1;
					cmd.emit  = 1'b1;
					step_done = 1'b1;
				end else begin
					step_done = 1'b0;
				end
				// the implied newline runs as a second pass over the same item
				if (step_done) begin
					if (!pass_q && stat.need_pass1) begin
						pass_d = 1'b1;
					end else begin
						cmd.finish = 1'b1;
						state_d    = C_IDLE;
					end
				end
			end
			C_FLUSH: begin
				if (stat.out_free) begin
					cmd.flush = 1'b1;
					if (stat.flush_last) begin
						cmd.flush_done = 1'b1;
						state_d        = C_EXEC;
					end
				end
			end
			default: begin
				state_d = C_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			pass_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pass_q  <= pass_d;
		end
	end

endmodule

// ----- sv/itt_dp.sv -----
module itt_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     text_byte,
	input  logic           end_of_text,
	input  itt_pkg::cmd_t  cmd,
	output itt_pkg::stat_t stat,
	input  logic           out_ready,
	output logic           out_valid,
	output logic [1:0]     token_kind,
	output logic [7:0]     token_byte,
	output logic           token_end,
	output logic           blanks_truncated,
	output logic           last_of_run
);

	logic [7:0]                  ch_q;
	logic                        eot_q;
	itt_pkg::pstate_t            ps_q;
	logic                        started_q;
	logic [itt_pkg::CNT_W-1:0]   cnt_q;
	logic                        trunc_q;
	logic [itt_pkg::IDX_W-1:0]   idx_q;
	logic                        tab_q [itt_pkg::MAX_PEND];

	logic [7:0]    cur_ch;
	itt_pkg::dec_t dec;
	itt_pkg::dec_t dec_nl;
	logic          blank;
	logic          need_pass1;
	logic          more_after;
	logic          out_valid_q;
	logic          store_blank;
	logic          cnt_full;

	assign cur_ch     = cmd.pass ? itt_pkg::CH_NL : ch_q;
	assign dec        = itt_pkg::decode(ps_q, cur_ch);
	// what the implied newline would do after this pass
	assign dec_nl     = itt_pkg::decode(dec.nstate, itt_pkg::CH_NL);
	assign blank      = itt_pkg::is_blank(cur_ch);
	assign need_pass1 = eot_q && (ch_q != itt_pkg::CH_NL);
	assign more_after = !cmd.pass && need_pass1 && (dec_nl.act != itt_pkg::ACT_NONE);
	assign cnt_full   = (cnt_q == itt_pkg::CNT_W'(itt_pkg::MAX_PEND));
	assign store_blank = cmd.apply && (dec.act == itt_pkg::ACT_PUT) && blank &&
		started_q && !cnt_full;

	always_comb begin
		stat.act        = dec.act;
		stat.blank      = blank;
		stat.pend_any   = (cnt_q != '0) && !dec.clear;
		stat.flush_last = (itt_pkg::CNT_W'(idx_q) == cnt_q - itt_pkg::CNT_W'(1));
		stat.need_pass1 = need_pass1;
		stat.out_free   = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q  <= text_byte;
			eot_q <= end_of_text;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q      <= itt_pkg::PS_IDLE;
			started_q <= 1'b0;
			cnt_q     <= '0;
			trunc_q   <= 1'b0;
			idx_q     <= '0;
		end else begin
			if (cmd.flush_done) begin
				idx_q <= '0;
				cnt_q <= '0;
			end else if (cmd.flush) begin
				idx_q <= idx_q + itt_pkg::IDX_W'(1);
			end
			priority if (cmd.finish && eot_q) begin
				ps_q      <= itt_pkg::PS_IDLE;
				started_q <= 1'b0;
				cnt_q     <= '0;
				trunc_q   <= 1'b0;
			end else if (cmd.apply) begin
				ps_q <= dec.nstate;
				unique case (dec.act)
					itt_pkg::ACT_PUT: begin
						if (blank) begin
							if (started_q) begin
								if (!cnt_full) begin
									cnt_q <= cnt_q + itt_pkg::CNT_W'(1);
								end else begin
									trunc_q <= 1'b1;
								end
							end
						end else begin
							cnt_q     <= '0;
							trunc_q   <= 1'b0;
							started_q <= 1'b1;
						end
					end
					itt_pkg::ACT_END: begin
						started_q <= 1'b0;
						cnt_q     <= '0;
						trunc_q   <= 1'b0;
					end
					default: begin
						if (dec.clear) begin
							started_q <= 1'b0;
							cnt_q     <= '0;
							trunc_q   <= 1'b0;
						end
					end
				endcase
			end else begin
				ps_q <= ps_q;
			end
		end
	end

	// held blank kinds, tab or space
	always_ff @(posedge clk) begin
		if (store_blank) begin
			tab_q[cnt_q[itt_pkg::IDX_W-1:0]] <= (cur_ch == itt_pkg::CH_TAB);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.flush) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.flush) begin
			token_kind       <= dec.kind;
			token_byte       <= tab_q[idx_q] ? itt_pkg::CH_TAB : itt_pkg::CH_SPACE;
			token_end        <= 1'b0;
			blanks_truncated <= trunc_q;
			last_of_run      <= 1'b0;
		end else if (cmd.emit) begin
			token_kind       <= dec.kind;
			token_byte       <= (dec.act == itt_pkg::ACT_END) ? 8'd0 : cur_ch;
			token_end        <= (dec.act == itt_pkg::ACT_END);
			blanks_truncated <= (dec.act == itt_pkg::ACT_PUT) && trunc_q && !dec.clear;
			last_of_run      <= !more_after;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- sv/ini_text_tokenizer_top.sv -----
// The first result of a byte is registered for output after its input transfer, later
// when held blanks or the implied newline at end of text come first.
// A byte is done before the next is taken: the implied newline at end of text runs as a
// second pass, held blanks are flushed one per output before the byte that follows them
// and the byte then resumes; output stalls hold the flow. The single-issue controller and the flush set this.
// Reset (arst_n low, asynchronous): parse state idle, blank count and flush index cleared,
// output empty; the held-blank store is not cleared and needs no clearing pass.
module ini_text_tokenizer_top (
	input logic       clk,
	input logic       arst_n,
	itt_in_if.sink    text_in,
	itt_out_if.source token_out
);

	itt_pkg::cmd_t  cmd;
	itt_pkg::stat_t stat;

	itt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (text_in.valid),
		.in_ready (text_in.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	itt_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.text_byte        (text_in.text_byte),
		.end_of_text      (text_in.end_of_text),
		.cmd              (cmd),
		.stat             (stat),
		.out_ready        (token_out.ready),
		.out_valid        (token_out.valid),
		.token_kind       (token_out.token_kind),
		.token_byte       (token_out.token_byte),
		.token_end        (token_out.token_end),
		.blanks_truncated (token_out.blanks_truncated),
		.last_of_run      (token_out.last_of_run)
	);

endmodule

// ----- sv/itt_checker.sv -----
`include "ini_text_tokenizer_top_assert.svh"

module itt_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] token_kind,
	input logic [7:0] token_byte,
	input logic       token_end,
	input logic       blanks_truncated,
	input logic       last_of_run
);

	// a stalled result holds
	`ITT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(token_kind) && $stable(token_byte) && $stable(token_end) && $stable(last_of_run), "stalled result changed")

	// one byte in flight: busy right after an input transfer
	`ITT_ASSERT_NXT(a_in_busy, in_valid && in_ready, !in_ready, "input taken while busy")

	`ITT_ASSERT_IMP(a_end_clean, out_valid && token_end, token_byte == 8'd0 && !blanks_truncated, "end marker carries data")

	`ITT_ASSERT_IMP(a_kind_range, out_valid, token_kind != 2'd3, "bad token kind")

endmodule

bind ini_text_tokenizer_top itt_checker u_itt_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (text_in.valid),
	.in_ready         (text_in.ready),
	.out_valid        (token_out.valid),
	.out_ready        (token_out.ready),
	.token_kind       (token_out.token_kind),
	.token_byte       (token_out.token_byte),
	.token_end        (token_out.token_end),
	.blanks_truncated (token_out.blanks_truncated),
	.last_of_run      (token_out.last_of_run)
);
